// ----- rtl/sample_block_statistics_macros.svh -----
// assertion macros used by the statistics block controller
`ifndef SAMPLE_BLOCK_STATISTICS_MACROS_SVH
`define SAMPLE_BLOCK_STATISTICS_MACROS_SVH

// same-cycle implication, checked out of reset
`define SBS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sbs assertion failed");

// next-cycle implication, checked out of reset
`define SBS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sbs assertion failed");

`endif

// ----- rtl/sbs_pkg.sv -----
// package: widths, operand selects and control structs of the statistics block
package sbs_pkg;

    localparam int SMP_W    = 24;
    localparam int CNT_W    = 17;
    localparam int SUM_W    = 40;
    localparam int SSQ_W    = 63;
    localparam int PROD_W   = 80;
    localparam int RAD_W    = 64;
    localparam int ROOT_W   = 32;
    localparam int RES_W    = 24;
    localparam int MCNT_W   = 6;

    localparam int DEF_MAX_SAMPLES = 65536;
    localparam int DEF_SAMPLE_BITS = 24;

    typedef enum logic [1:0] {
        DS_MEAN = 2'd0,
        DS_SQN  = 2'd1,
        DS_VAR  = 2'd2,
        DS_MSQ  = 2'd3
    } t_dsel;

    typedef enum logic [1:0] {
        SS_VAR = 2'd0,
        SS_MSQ = 2'd1,
        SS_RAW = 2'd2
    } t_ssel;

    typedef struct packed {
        logic  take;
        logic  clr;
        logic  mul_start;
        logic  div_start;
        t_dsel div_sel;
        logic  sqrt_start;
        t_ssel sqrt_sel;
    } t_cmd;

    typedef struct packed {
        logic n_ge2;
        logic mul_done;
        logic div_done;
        logic sqrt_done;
    } t_sts;

endpackage

// ----- rtl/sbs_div.sv -----
// restoring divider, one quotient bit per cycle
module sbs_div #(
    parameter int DW = sbs_pkg::PROD_W,
    parameter int VW = sbs_pkg::CNT_W
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quot
);

    localparam int CW = $clog2(DW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_dvs;
    logic [DW-1:0] r_quot;
    logic [VW:0]   trial;
    logic [VW:0]   diff;
    logic          ge;

    assign trial = {r_rem, r_quot[DW-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign ge    = !diff[VW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_dvs  <= i_divisor;
            r_quot <= i_dividend;
        end else if (r_busy) begin
            r_rem  <= ge ? diff[VW-1:0] : trial[VW-1:0];
            r_quot <= {r_quot[DW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ----- rtl/sbs_sqrt.sv -----
// digit-by-digit integer square root, one root bit per cycle
module sbs_sqrt #(
    parameter int RW = sbs_pkg::RAD_W
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [RW-1:0]   i_rad,
    output logic            o_done,
    output logic [RW/2-1:0] o_root
);

    localparam int HW = RW / 2;
    localparam int CW = $clog2(HW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [RW-1:0] r_rad;
    logic [HW:0]   r_rem;
    logic [HW-1:0] r_root;
    logic [HW+2:0] trial_rem;
    logic [HW+2:0] trial;
    logic [HW+2:0] diff;
    logic          ge;

    assign trial_rem = {r_rem, r_rad[RW-1:RW-2]};
    assign trial     = {1'b0, r_root, 2'b01};
    assign ge        = trial_rem >= trial;
    assign diff      = trial_rem - trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(HW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[RW-3:0], 2'b00};
            r_rem  <= ge ? diff[HW:0] : trial_rem[HW:0];
            r_root <= {r_root[HW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ----- rtl/sbs_datapath.sv -----
// datapath: sample stage, running accumulators, serial multiply, divide and root
module sbs_datapath #(
    parameter int MAX_SAMPLES = sbs_pkg::DEF_MAX_SAMPLES,
    parameter int SAMPLE_BITS = sbs_pkg::DEF_SAMPLE_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  sbs_pkg::t_cmd                     i_cmd,
    output sbs_pkg::t_sts                     o_sts,
    input  logic signed [sbs_pkg::SMP_W-1:0]  i_sample,
    input  logic                              i_invalid,
    output logic [sbs_pkg::CNT_W-1:0]         o_total_count,
    output logic [sbs_pkg::CNT_W-1:0]         o_valid_count,
    output logic signed [sbs_pkg::SMP_W-1:0]  o_min_value,
    output logic signed [sbs_pkg::SMP_W-1:0]  o_max_value,
    output logic signed [sbs_pkg::SMP_W-1:0]  o_min_positive,
    output logic                              o_positive_found,
    output logic signed [sbs_pkg::SUM_W-1:0]  o_sum_total,
    output logic [sbs_pkg::SSQ_W-1:0]         o_sum_of_squares,
    output logic signed [sbs_pkg::RES_W-1:0]  o_mean_value,
    output logic [sbs_pkg::RES_W-1:0]         o_sigma_value,
    output logic [sbs_pkg::RES_W-1:0]         o_rms_value,
    output logic                              o_empty_res
);

    localparam int SW = sbs_pkg::SMP_W;
    localparam int SH = SW - SAMPLE_BITS;
    localparam logic signed [SW-1:0] POS_MAX = SW'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
    localparam logic [sbs_pkg::CNT_W-1:0] CNT_MAX = sbs_pkg::CNT_W'(MAX_SAMPLES);

    logic signed [SW-1:0]               x_ext;
    logic signed [SW-1:0]               r_px;
    logic                               r_pbad;
    logic                               r_pvld;
    logic [sbs_pkg::CNT_W-1:0]          r_seen;
    logic [sbs_pkg::CNT_W-1:0]          r_good;
    logic signed [SW-1:0]               r_min;
    logic signed [SW-1:0]               r_max;
    logic signed [SW-1:0]               r_minpos;
    logic                               r_pos;
    logic signed [sbs_pkg::SUM_W-1:0]   r_sum;
    logic [sbs_pkg::SSQ_W-1:0]          r_ssq;
    logic [SW-1:0]                      mag;
    logic [2*SW-1:0]                    sq;
    logic                               upd;

    logic [sbs_pkg::SUM_W-1:0]          s_abs;
    logic [sbs_pkg::PROD_W-1:0]         r_mcand;
    logic [sbs_pkg::SUM_W-1:0]          r_mplier;
    logic [sbs_pkg::PROD_W-1:0]         r_prod;
    logic [sbs_pkg::MCNT_W-1:0]         r_mcnt;
    logic                               r_mbusy;
    logic                               r_mdone;

    logic [sbs_pkg::PROD_W-1:0]         div_dividend;
    logic [sbs_pkg::CNT_W-1:0]          div_divisor;
    logic                               div_done;
    logic [sbs_pkg::PROD_W-1:0]         div_quot;
    logic [sbs_pkg::SSQ_W-1:0]          dev_sq;
    sbs_pkg::t_dsel                     r_dsel;
    logic [SW-1:0]                      r_meanq;

    logic [sbs_pkg::RAD_W-1:0]          sqrt_rad;
    logic                               sqrt_done;
    logic [sbs_pkg::ROOT_W-1:0]         sqrt_root;
    sbs_pkg::t_ssel                     r_ssel;
    logic [sbs_pkg::ROOT_W-1:0]         r_sig_root;
    logic [sbs_pkg::ROOT_W-1:0]         r_rms_root;
    logic [SW:0]                        span;
    logic                               n_ge2;

    // low SAMPLE_BITS bits, sign from the top one
    logic signed [SW-1:0] x_shl;
    assign x_shl = i_sample <<< SH;
    assign x_ext = x_shl >>> SH;

    assign mag = r_px[SW-1] ? SW'(-r_px) : r_px;
    assign sq  = mag * mag;
    assign upd = r_pvld && !r_pbad && (r_seen < CNT_MAX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvld <= 1'b0;
        end else begin
            r_pvld <= i_cmd.take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_px   <= x_ext;
            r_pbad <= i_invalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr) begin
            r_seen   <= '0;
            r_good   <= '0;
            r_min    <= '0;
            r_max    <= '0;
            r_minpos <= POS_MAX;
            r_pos    <= 1'b0;
            r_sum    <= '0;
            r_ssq    <= '0;
        end else if (r_pvld && (r_seen < CNT_MAX)) begin
            r_seen <= r_seen + 1'b1;
            if (upd) begin
                if (r_good == '0) begin
                    r_min <= r_px;
                    r_max <= r_px;
                end else begin
                    if (r_px < r_min) r_min <= r_px;
                    if (r_px > r_max) r_max <= r_px;
                end
                if ((r_px > 0) && (!r_pos || (r_px < r_minpos))) begin
                    r_minpos <= r_px;
                    r_pos    <= 1'b1;
                end
                r_sum  <= r_sum + sbs_pkg::SUM_W'(r_px);
                r_ssq  <= r_ssq + sbs_pkg::SSQ_W'(sq);
                r_good <= r_good + 1'b1;
            end
        end
    end

    // shift-add square of |sum|
    assign s_abs = r_sum[sbs_pkg::SUM_W-1] ? sbs_pkg::SUM_W'(-r_sum) : sbs_pkg::SUM_W'(r_sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mbusy <= 1'b0;
            r_mdone <= 1'b0;
            r_mcnt  <= '0;
        end else begin
            r_mdone <= 1'b0;
            if (i_cmd.mul_start) begin
                r_mbusy <= 1'b1;
                r_mcnt  <= sbs_pkg::MCNT_W'(sbs_pkg::SUM_W);
            end else if (r_mbusy) begin
                r_mcnt <= r_mcnt - 1'b1;
                if (r_mcnt == sbs_pkg::MCNT_W'(1)) begin
                    r_mbusy <= 1'b0;
                    r_mdone <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_start) begin
            r_mcand  <= sbs_pkg::PROD_W'(s_abs);
            r_mplier <= s_abs;
            r_prod   <= '0;
        end else if (r_mbusy) begin
            r_mcand  <= {r_mcand[sbs_pkg::PROD_W-2:0], 1'b0};
            r_mplier <= {1'b0, r_mplier[sbs_pkg::SUM_W-1:1]};
            if (r_mplier[0]) r_prod <= r_prod + r_mcand;
        end
    end

    // sumsq minus sum^2/n, clamped at zero
    assign dev_sq = (r_ssq > div_quot[sbs_pkg::SSQ_W-1:0])
                  ? r_ssq - div_quot[sbs_pkg::SSQ_W-1:0] : '0;

    always_comb begin
        div_divisor = r_good;
        case (i_cmd.div_sel)
            sbs_pkg::DS_MEAN: div_dividend = sbs_pkg::PROD_W'(s_abs);
            sbs_pkg::DS_SQN:  div_dividend = r_prod;
            sbs_pkg::DS_VAR: begin
                div_dividend = sbs_pkg::PROD_W'(dev_sq);
                div_divisor  = r_good - 1'b1;
            end
            default:          div_dividend = sbs_pkg::PROD_W'(r_ssq);
        endcase
    end

    sbs_div #(
        .DW (sbs_pkg::PROD_W),
        .VW (sbs_pkg::CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) r_dsel <= i_cmd.div_sel;
        if (div_done && (r_dsel == sbs_pkg::DS_MEAN)) r_meanq <= div_quot[SW-1:0];
    end

    assign sqrt_rad = (i_cmd.sqrt_sel == sbs_pkg::SS_RAW)
                    ? sbs_pkg::RAD_W'(r_ssq)
                    : sbs_pkg::RAD_W'(div_quot[sbs_pkg::SSQ_W-1:0]);

    sbs_sqrt #(
        .RW (sbs_pkg::RAD_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sqrt_start),
        .i_rad   (sqrt_rad),
        .o_done  (sqrt_done),
        .o_root  (sqrt_root)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_start) r_ssel <= i_cmd.sqrt_sel;
        if (sqrt_done) begin
            if (r_ssel == sbs_pkg::SS_VAR) r_sig_root <= sqrt_root;
            else r_rms_root <= sqrt_root;
        end
    end

    assign n_ge2 = r_good >= sbs_pkg::CNT_W'(2);
    assign span  = (SW + 1)'(r_max) - (SW + 1)'(r_min);

    assign o_sts.n_ge2     = n_ge2;
    assign o_sts.mul_done  = r_mdone;
    assign o_sts.div_done  = div_done;
    assign o_sts.sqrt_done = sqrt_done;

    assign o_total_count    = r_seen;
    assign o_valid_count    = r_good;
    assign o_min_value      = r_min;
    assign o_max_value      = r_max;
    assign o_min_positive   = r_minpos;
    assign o_positive_found = r_pos;
    assign o_sum_total      = r_sum;
    assign o_sum_of_squares = r_ssq;
    assign o_empty_res      = (r_good == '0);

    assign o_mean_value = !n_ge2 ? '0
                        : (r_sum[sbs_pkg::SUM_W-1] ? SW'(-r_meanq) : r_meanq);
    assign o_sigma_value = !n_ge2 ? span[SW-1:0]
                         : ((r_sig_root[sbs_pkg::ROOT_W-1:SW] != '0) ? '1
                            : r_sig_root[SW-1:0]);
    assign o_rms_value = (r_rms_root[sbs_pkg::ROOT_W-1:SW] != '0) ? '1
                       : r_rms_root[SW-1:0];

endmodule

// ----- rtl/sbs_ctrl.sv -----
// controller: run accumulation, then sequence the closing arithmetic
`include "sample_block_statistics_macros.svh"
module sbs_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_last,
    output logic          o_stall,
    output logic          o_valid,
    input  logic          i_stall,
    output sbs_pkg::t_cmd o_cmd,
    input  sbs_pkg::t_sts i_sts
);

    typedef enum logic [10:0] {
        S_RUN   = 11'b00000000001,
        S_DRAIN = 11'b00000000010,
        S_EVAL  = 11'b00000000100,
        S_MUL   = 11'b00000001000,
        S_DIVM  = 11'b00000010000,
        S_DIVQ  = 11'b00000100000,
        S_DIVV  = 11'b00001000000,
        S_SQV   = 11'b00010000000,
        S_DIVR  = 11'b00100000000,
        S_SQR   = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } t_state;

    t_state        r_state;
    t_state        n_state;
    sbs_pkg::t_cmd cmd;

    always_comb begin
        n_state        = r_state;
        cmd            = '0;
        cmd.div_sel    = sbs_pkg::DS_MEAN;
        cmd.sqrt_sel   = sbs_pkg::SS_VAR;
        unique case (r_state)
            S_RUN: begin
                cmd.take = i_valid;
                if (i_valid && i_last) n_state = S_DRAIN;
            end
            S_DRAIN: n_state = S_EVAL;
            S_EVAL: begin
                if (i_sts.n_ge2) begin
                    cmd.mul_start = 1'b1;
                    n_state       = S_MUL;
                end else begin
                    cmd.sqrt_start = 1'b1;
                    cmd.sqrt_sel   = sbs_pkg::SS_RAW;
                    n_state        = S_SQR;
                end
            end
            S_MUL: begin
                if (i_sts.mul_done) begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = sbs_pkg::DS_MEAN;
                    n_state       = S_DIVM;
                end
            end
            S_DIVM: begin
                if (i_sts.div_done) begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = sbs_pkg::DS_SQN;
                    n_state       = S_DIVQ;
                end
            end
            S_DIVQ: begin
                if (i_sts.div_done) begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = sbs_pkg::DS_VAR;
                    n_state       = S_DIVV;
                end
            end
            S_DIVV: begin
                if (i_sts.div_done) begin
                    cmd.sqrt_start = 1'b1;
                    cmd.sqrt_sel   = sbs_pkg::SS_VAR;
                    n_state        = S_SQV;
                end
            end
            S_SQV: begin
                if (i_sts.sqrt_done) begin
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = sbs_pkg::DS_MSQ;
                    n_state       = S_DIVR;
                end
            end
            S_DIVR: begin
                if (i_sts.div_done) begin
                    cmd.sqrt_start = 1'b1;
                    cmd.sqrt_sel   = sbs_pkg::SS_MSQ;
                    n_state        = S_SQR;
                end
            end
            S_SQR: begin
                if (i_sts.sqrt_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (!i_stall) begin
                    cmd.clr = 1'b1;
                    n_state = S_RUN;
                end
            end
            default: n_state = S_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RUN;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd   = cmd;
    assign o_stall = (r_state != S_RUN);
    assign o_valid = (r_state == S_OUT);

    `SBS_ASSERT_IMP(a_result_holds_input, i_clk, i_rst_n, o_valid, o_stall)
    `SBS_ASSERT_NXT(a_last_drains, i_clk, i_rst_n, cmd.take && i_last, r_state == S_DRAIN)
    `SBS_ASSERT_IMP(a_div_done_in_div, i_clk, i_rst_n, i_sts.div_done, (r_state == S_DIVM) || (r_state == S_DIVQ) || (r_state == S_DIVV) || (r_state == S_DIVR))

endmodule

// ----- rtl/sample_block_statistics.sv -----
// top level: running min, max, mean, sigma and rms over a sample run
//
//   channel   direction  handshake          payload
//   samples   in         i_valid / o_stall  i_sample, i_invalid, i_last
//   results   out        o_valid / i_stall  o_total_count .. o_empty_res
//
// one sample per cycle while a run accumulates
// after the last sample the input stalls: the drain and eval states settle, then with two
// or more valid samples a serial square, four divides and two roots follow,
// otherwise a single root
// the result holds until taken; the input stays stalled meanwhile
// synchronous active-low reset clears the run
module sample_block_statistics #(
    parameter int MAX_SAMPLES = sbs_pkg::DEF_MAX_SAMPLES,
    parameter int SAMPLE_BITS = sbs_pkg::DEF_SAMPLE_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [sbs_pkg::SMP_W-1:0]  i_sample,
    input  logic                              i_invalid,
    input  logic                              i_last,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [sbs_pkg::CNT_W-1:0]         o_total_count,
    output logic [sbs_pkg::CNT_W-1:0]         o_valid_count,
    output logic signed [sbs_pkg::SMP_W-1:0]  o_min_value,
    output logic signed [sbs_pkg::SMP_W-1:0]  o_max_value,
    output logic signed [sbs_pkg::SMP_W-1:0]  o_min_positive,
    output logic                              o_positive_found,
    output logic signed [sbs_pkg::SUM_W-1:0]  o_sum_total,
    output logic [sbs_pkg::SSQ_W-1:0]         o_sum_of_squares,
    output logic signed [sbs_pkg::RES_W-1:0]  o_mean_value,
    output logic [sbs_pkg::RES_W-1:0]         o_sigma_value,
    output logic [sbs_pkg::RES_W-1:0]         o_rms_value,
    output logic                              o_empty_res
);

    sbs_pkg::t_cmd cmd;
    sbs_pkg::t_sts sts;

    sbs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_last  (i_last),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (cmd),
        .i_sts   (sts)
    );

    sbs_datapath #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_sample         (i_sample),
        .i_invalid        (i_invalid),
        .o_total_count    (o_total_count),
        .o_valid_count    (o_valid_count),
        .o_min_value      (o_min_value),
        .o_max_value      (o_max_value),
        .o_min_positive   (o_min_positive),
        .o_positive_found (o_positive_found),
        .o_sum_total      (o_sum_total),
        .o_sum_of_squares (o_sum_of_squares),
        .o_mean_value     (o_mean_value),
        .o_sigma_value    (o_sigma_value),
        .o_rms_value      (o_rms_value),
        .o_empty_res      (o_empty_res)
    );

endmodule
